// File: rtl/siphash_pkg.sv
// shared types and constants for the keyed siphash block
// used by siphash_round and siphash_keyed_hash, no dependencies
package siphash_pkg;

    localparam int WORD_W = 64;
    localparam int COUNT_W = 4;
    localparam int LEN_W = 8;
    localparam int CFG_INDEX_W = 1;

    localparam int DEF_COMPRESS_ROUNDS = 2;
    localparam int DEF_FINAL_ROUNDS = 4;

    localparam logic [WORD_W-1:0] INIT_ZERO = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] INIT_ONE = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] INIT_TWO = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] INIT_THREE = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FINAL_MARK = 64'hff;
    localparam int LENGTH_SHIFT = 56;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } t_lanes;

endpackage

// File: rtl/siphash_round.sv
// one siphash round over the four lanes, combinational
// depends on siphash_pkg for the lane struct
module siphash_round (
    input  siphash_pkg::t_lanes i_lanes,
    output siphash_pkg::t_lanes o_lanes
);

    logic [siphash_pkg::WORD_W-1:0] a0, a1, a2, a3;
    logic [siphash_pkg::WORD_W-1:0] b0, b1, b2, b3;

    always_comb begin
        // first half
        a0 = i_lanes.v0 + i_lanes.v1;
        a1 = {i_lanes.v1[50:0], i_lanes.v1[63:51]} ^ a0;
        a0 = {a0[31:0], a0[63:32]};
        a2 = i_lanes.v2 + i_lanes.v3;
        a3 = {i_lanes.v3[47:0], i_lanes.v3[63:48]} ^ a2;
        // second half
        b0 = a0 + a3;
        b3 = {a3[42:0], a3[63:43]} ^ b0;
        b2 = a2 + a1;
        b1 = {a1[46:0], a1[63:47]} ^ b2;
        b2 = {b2[31:0], b2[63:32]};
        o_lanes.v0 = b0;
        o_lanes.v1 = b1;
        o_lanes.v2 = b2;
        o_lanes.v3 = b3;
    end

endmodule

// File: rtl/siphash_keyed_hash.sv
// Keyed SipHash (default 2-4) over 64-bit little-endian message words. One
// shared SipRound unit runs one round per cycle under a small sequencer.
// A word that is not last is taken in while idle, runs COMPRESS_ROUNDS rounds
// and returns to idle; the last item runs COMPRESS_ROUNDS rounds (short last
// word) or 2 * COMPRESS_ROUNDS (full last word, plus a length-only block), then
// FINAL_ROUNDS rounds of finalization, and the result register is loaded once
// the output register is free. o_in_ready is high only while the sequencer is
// idle. A finished hash sits in the output register while the next message is
// taken in. Key writes take effect at the next message start.
// depends on siphash_pkg and siphash_round
module siphash_keyed_hash #(
    parameter int COMPRESS_ROUNDS = siphash_pkg::DEF_COMPRESS_ROUNDS,
    parameter int FINAL_ROUNDS = siphash_pkg::DEF_FINAL_ROUNDS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [siphash_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [siphash_pkg::WORD_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [siphash_pkg::WORD_W-1:0]        i_msg_word,
    input  logic [siphash_pkg::COUNT_W-1:0]       i_byte_count,
    input  logic                                  i_is_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [siphash_pkg::WORD_W-1:0]        o_hash_value
);

    localparam int MAX_ROUNDS =
        (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS : FINAL_ROUNDS;
    localparam int CNT_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    localparam logic [CNT_W-1:0] COMP_LAST = CNT_W'(COMPRESS_ROUNDS - 1);
    localparam logic [CNT_W-1:0] FIN_LAST = CNT_W'(FINAL_ROUNDS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    siphash_pkg::t_lanes r_lanes, n_lanes, w_rnd, w_base;
    logic [siphash_pkg::WORD_W-1:0] r_key_low, r_key_high;
    logic [siphash_pkg::WORD_W-1:0] r_block, n_block;
    logic [siphash_pkg::LEN_W-1:0] r_len, n_len;
    logic r_mid, n_mid;
    logic r_tail, n_tail;
    logic r_last, n_last;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic [siphash_pkg::WORD_W-1:0] r_hash, n_hash;

    logic in_xfer;
    logic full_word;
    logic [siphash_pkg::LEN_W-1:0] len_base, len_next;
    logic [siphash_pkg::WORD_W-1:0] masked_word, len_block, new_block;

    siphash_round u_round (
        .i_lanes(r_lanes),
        .o_lanes(w_rnd)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hash_value = r_hash;
    assign in_xfer = i_in_valid && o_in_ready;

    always_comb begin
        // byte count only matters on the last item, above eight counts as eight
        full_word = !i_is_last || (i_byte_count >= siphash_pkg::FULL_COUNT);
        // length restarts at zero when a message opens
        len_base = r_mid ? r_len : '0;
        len_next = full_word ? len_base + 8'd8
                             : len_base + siphash_pkg::LEN_W'(i_byte_count);
        for (int b = 0; b < 8; b++) begin
            masked_word[8*b +: 8] = (siphash_pkg::COUNT_W'(b) < i_byte_count)
                                    ? i_msg_word[8*b +: 8] : 8'h00;
        end
        new_block = full_word ? i_msg_word
            : (masked_word | (siphash_pkg::WORD_W'(len_next) << siphash_pkg::LENGTH_SHIFT));
        len_block = siphash_pkg::WORD_W'(r_len) << siphash_pkg::LENGTH_SHIFT;

        if (r_mid) begin
            w_base = r_lanes;
        end else begin
            w_base.v0 = siphash_pkg::INIT_ZERO ^ r_key_low;
            w_base.v1 = siphash_pkg::INIT_ONE ^ r_key_high;
            w_base.v2 = siphash_pkg::INIT_TWO ^ r_key_low;
            w_base.v3 = siphash_pkg::INIT_THREE ^ r_key_high;
        end

        n_state = r_state;
        n_lanes = r_lanes;
        n_block = r_block;
        n_len = r_len;
        n_mid = r_mid;
        n_tail = r_tail;
        n_last = r_last;
        n_cnt = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_hash = r_hash;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_lanes = w_base;
                    n_lanes.v3 = w_base.v3 ^ new_block;
                    n_block = new_block;
                    n_len = len_next;
                    n_mid = 1'b1;
                    n_tail = i_is_last && full_word;
                    n_last = i_is_last;
                    n_cnt = '0;
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                n_lanes = w_rnd;
                if (r_cnt == COMP_LAST) begin
                    n_lanes.v0 = w_rnd.v0 ^ r_block;
                    n_cnt = '0;
                    if (r_tail) begin
                        // full last word: follow with a length-only block
                        n_lanes.v3 = w_rnd.v3 ^ len_block;
                        n_block = len_block;
                        n_tail = 1'b0;
                    end else if (r_last) begin
                        n_lanes.v2 = w_rnd.v2 ^ siphash_pkg::FINAL_MARK;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                n_lanes = w_rnd;
                if (r_cnt == FIN_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_hash = r_lanes.v0 ^ r_lanes.v1 ^ r_lanes.v2 ^ r_lanes.v3;
                    n_mid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mid <= 1'b0;
            r_len <= '0;
            r_tail <= 1'b0;
            r_last <= 1'b0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
            r_key_low <= '0;
            r_key_high <= '0;
        end else begin
            r_state <= n_state;
            r_mid <= n_mid;
            r_len <= n_len;
            r_tail <= n_tail;
            r_last <= n_last;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    siphash_pkg::CFG_KEY_LOW: r_key_low <= i_cfg_data;
                    siphash_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_lanes <= n_lanes;
        r_block <= n_block;
        r_hash <= n_hash;
    end

`ifndef NO_ASSERTIONS
    a_xfer_starts_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_COMP))
        else $error("accepted item did not start compression");

    a_tail_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail |-> r_last)
        else $error("length block pending on an item that is not last");

    a_fin_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_cnt <= FIN_LAST))
        else $error("finalization round count out of range");

    a_pending_hash_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_hash)))
        else $error("pending hash overwritten");

    a_done_clears_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=> (!r_mid && r_out_valid))
        else $error("finished message not closed");
`endif

endmodule
